// ===== rtl/fuwog_pkg.sv =====
// Shared types and constants for the flash update write-order guard.
// No dependencies; imported by the sequencer, the divider and the port checker.
package fuwog_pkg;

   // Command codes carried in the operation field
   localparam logic [2:0] OP_ABORT         = 3'd0;
   localparam logic [2:0] OP_BEGIN_ERASE   = 3'd1;
   localparam logic [2:0] OP_END_ERASE     = 3'd2;
   localparam logic [2:0] OP_CHECK_PROGRAM = 3'd3;
   localparam logic [2:0] OP_END_PROGRAM   = 3'd4;

   // Guard phases
   localparam logic [1:0] PHASE_IDLE        = 2'd0;
   localparam logic [1:0] PHASE_ERASING     = 2'd1;
   localparam logic [1:0] PHASE_READY       = 2'd2;
   localparam logic [1:0] PHASE_PROGRAMMING = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_ERASE_BLOCK_BYTES = 2'd0;
   localparam logic [1:0] CSR_WINDOW_START      = 2'd1;
   localparam logic [1:0] CSR_WINDOW_END        = 2'd2;

   // Erase block size after reset
   localparam logic [31:0] ERASE_BLOCK_RESET = 32'd4096;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 40;

   // Divider step count and its counter width
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Handshake between sequencer and divider
   typedef struct packed {
      logic start;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/fuwog_div.sv =====
// Iterative restoring divider that keeps only the remainder: one dividend bit per cycle.
// Depends on fuwog_pkg; used by the top level for the erase alignment check.
module fuwog_div
   import fuwog_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  div_req_type    ctl,
   input  logic [31:0]    dividend,
   input  logic [31:0]    divisor,
   output div_status_type status,
   output logic [31:0]    remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          num_ff, num_in;
   logic [33:0]          diff;

   // Trial subtraction of the divisor from the shifted partial remainder
   assign diff = {1'b0, rem_ff, num_ff[31]} - {2'b00, divisor};

   // Sequence the steps
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         num_in  = dividend;
      end else if (busy_ff) begin
         if (diff[33]) begin
            rem_in = {rem_ff[30:0], num_ff[31]};
         end else begin
            rem_in = diff[31:0];
         end
         num_in = {num_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

// ===== rtl/flash_update_write_order_guard.sv =====
// A request passes the execute state, then, for a begin erase that passes the range
// checks, the divide state while the iterative divider runs, then the output state.
// One request is in flight at a time: a new request is taken only once the result
// is loaded for output, which waits while a previous result is stalled.
// Synchronous active-high reset clears the guard to idle, the erase block size
// to 4096 and the window to zero. Depends on fuwog_pkg and fuwog_div.
module flash_update_write_order_guard
   import fuwog_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] operation, [34:3] address, [66:35] erase block count, [82:67] length,
   // [83] success, [87:84] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] ok, [2:1] phase, [3] finish_allowed, [35:4] next_address, [39:36] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_OUT
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // Configuration
   logic [31:0] block_bytes_ff, win_start_ff, win_end_ff;

   // Guard state
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] erased_start_ff, erased_start_in;
   logic [31:0] erased_end_ff, erased_end_in;
   logic [31:0] wptr_ff, wptr_in;

   // Latched request
   logic [2:0]  op_ff;
   logic [31:0] addr_ff, count_ff;
   logic [15:0] len_ff;
   logic        succ_ff;

   // Working registers
   logic        ok_ff, ok_in;
   logic [63:0] prod_ff, prod_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   div_req_type    div_ctl;
   div_status_type div_status;
   logic [31:0]    div_rem;

   logic        req_fire;
   logic        erase_pre_ok, program_ok, fin;
   logic [31:0] avail;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // Range checks on the latched request
   assign avail = win_end_ff - addr_ff;
   assign erase_pre_ok = (block_bytes_ff != '0) && (count_ff != '0) &&
                         (win_start_ff < win_end_ff) && (addr_ff >= win_start_ff) &&
                         (addr_ff < win_end_ff);
   assign program_ok = (len_ff != '0) &&
                       ((phase_ff == PHASE_READY) || (phase_ff == PHASE_PROGRAMMING)) &&
                       (addr_ff == wptr_ff) && (addr_ff >= erased_start_ff) &&
                       (addr_ff < erased_end_ff) &&
                       ({16'h0000, len_ff} <= (erased_end_ff - addr_ff));
   assign fin = (phase_ff == PHASE_PROGRAMMING) && (wptr_ff > erased_start_ff);

   fuwog_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (addr_ff),
      .divisor   (block_bytes_ff),
      .status    (div_status),
      .remainder (div_rem)
   );

   // Sequencer and guard update
   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      erased_start_in = erased_start_ff;
      erased_end_in   = erased_end_ff;
      wptr_in         = wptr_ff;
      ok_in           = ok_ff;
      prod_in         = prod_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      div_ctl.start   = 1'b0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ok_in    = 1'b0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            case (op_ff)
               OP_ABORT: begin
                  phase_in        = PHASE_IDLE;
                  erased_start_in = '0;
                  erased_end_in   = '0;
                  wptr_in         = '0;
               end
               OP_BEGIN_ERASE: begin
                  if (erase_pre_ok) begin
                     prod_in       = 64'(count_ff) * 64'(block_bytes_ff);
                     div_ctl.start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               OP_END_ERASE: begin
                  if (phase_ff == PHASE_ERASING) begin
                     if (succ_ff) begin
                        phase_in = PHASE_READY;
                     end else begin
                        phase_in        = PHASE_IDLE;
                        erased_start_in = '0;
                        erased_end_in   = '0;
                        wptr_in         = '0;
                     end
                  end
               end
               OP_CHECK_PROGRAM: begin
                  ok_in = program_ok;
               end
               OP_END_PROGRAM: begin
                  if (succ_ff && ((phase_ff == PHASE_READY) ||
                                  (phase_ff == PHASE_PROGRAMMING))) begin
                     wptr_in  = wptr_ff + 32'(len_ff);
                     phase_in = PHASE_PROGRAMMING;
                  end
               end
               default: begin
               end
            endcase
         end
         S_DIV: begin
            // Commit the erase range once alignment and span are known
            if (div_status.done) begin
               state_in = S_OUT;
               if ((div_rem == '0) && (prod_ff <= {32'h0000_0000, avail})) begin
                  ok_in           = 1'b1;
                  erased_start_in = addr_ff;
                  erased_end_in   = addr_ff + prod_ff[31:0];
                  wptr_in         = addr_ff;
                  phase_in        = PHASE_ERASING;
               end
            end
         end
         S_OUT: begin
            // Load the result once the output slot is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'h0, wptr_ff, fin, phase_ff, ok_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         phase_ff        <= PHASE_IDLE;
         erased_start_ff <= '0;
         erased_end_ff   <= '0;
         wptr_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         ok_ff           <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         erased_start_ff <= erased_start_in;
         erased_end_ff   <= erased_end_in;
         wptr_ff         <= wptr_in;
         rsp_valid_ff    <= rsp_valid_in;
         ok_ff           <= ok_in;
      end
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_tdata[2:0];
         addr_ff  <= req_tdata[34:3];
         count_ff <= req_tdata[66:35];
         len_ff   <= req_tdata[82:67];
         succ_ff  <= req_tdata[83];
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= ERASE_BLOCK_RESET;
         win_start_ff   <= '0;
         win_end_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ERASE_BLOCK_BYTES: block_bytes_ff <= csr_data;
            CSR_WINDOW_START:      win_start_ff   <= csr_data;
            CSR_WINDOW_END:        win_end_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/fuwog_chk.sv =====
// Port-level checker for the write-order guard, bound to the top level.
// Depends on fuwog_pkg for phase codes and stream widths.
module fuwog_chk
   import fuwog_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // One request at a time: busy right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one in progress");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // An approved request never leaves the guard idle
   a_ok_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[2:1] != PHASE_IDLE)
      else $error("ok reported in idle phase");

   // Finishing only while programming
   a_fin_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2:1] == PHASE_PROGRAMMING)
      else $error("finish allowed outside programming");

   // Idle guard has a cleared write pointer and no finish allowed
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:1] == PHASE_IDLE) |->
         (rsp_tdata[35:4] == 32'h0000_0000) && !rsp_tdata[3])
      else $error("idle phase with nonzero next address");

endmodule

bind flash_update_write_order_guard fuwog_chk u_fuwog_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
